// File: rtl/fdsr_pkg.sv
package fdsr_pkg;

  localparam int unsigned IN_DW  = 40;
  localparam int unsigned OUT_DW = 40;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_VEL_THR   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LIMIT     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RAMP_STRT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RAMP_STOP = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RAMP_END  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_TICK_MS   = 3'd6;

  localparam logic [7:0]  TICK_MS_RST = 8'd2;
  localparam logic [15:0] UNITY       = 16'd256;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [15:0] SAT_POS     = 16'h7FFF;
  localparam logic [15:0] SAT_NEG     = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MULV,
    ST_MULN,
    ST_DIVS,
    ST_DIVW,
    ST_MUL2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic mulv;
    logic muln;
    logic div_start;
    logic mul2;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic interp;
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/fdsr_div.sv
module fdsr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [15:0] rem_r,  rem_nxt;
  logic [31:0] quo_r,  quo_nxt;
  logic [4:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  // one restoring step per cycle, dividend bits enter from the top
  always_comb begin
    rem_sh   = {rem_r, quo_r[31]};
    rem_sub  = rem_sh - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!rem_sub[16]) begin
        rem_nxt = rem_sub[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[15:0];

endmodule

// File: rtl/fdsr_ctrl.sv
module fdsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fdsr_pkg::dp_sts_t sts,
  output fdsr_pkg::dp_cmd_t cmd
);

  fdsr_pkg::state_t state_r, state_nxt;
  logic             out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      fdsr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = fdsr_pkg::ST_CALC;
        end
      end
      fdsr_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = fdsr_pkg::ST_MULV;
      end
      fdsr_pkg::ST_MULV: begin
        cmd.mulv  = 1'b1;
        state_nxt = fdsr_pkg::ST_MULN;
      end
      fdsr_pkg::ST_MULN: begin
        cmd.muln  = 1'b1;
        state_nxt = sts.interp ? fdsr_pkg::ST_DIVS : fdsr_pkg::ST_MUL2;
      end
      fdsr_pkg::ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = fdsr_pkg::ST_DIVW;
      end
      fdsr_pkg::ST_DIVW: begin
        if (sts.div_done) begin
          state_nxt = fdsr_pkg::ST_MUL2;
        end
      end
      fdsr_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = fdsr_pkg::ST_FIN;
      end
      fdsr_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_vld_r || out_tready) begin
          cmd.fin     = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = fdsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fdsr_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == fdsr_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;

endmodule

// File: rtl/fdsr_dp.sv
module fdsr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fdsr_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [fdsr_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic [fdsr_pkg::IN_DW-1:0]    in_tdata,
  input  fdsr_pkg::dp_cmd_t             cmd,
  output fdsr_pkg::dp_sts_t             sts,
  output logic [fdsr_pkg::OUT_DW-1:0]   out_tdata
);

  // configuration
  logic [15:0] gain_r;
  logic [14:0] vel_thr_r;
  logic [14:0] limit_r;
  logic [15:0] ramp_strt_r;
  logic [15:0] ramp_stop_r;
  logic [15:0] ramp_end_r;
  logic [7:0]  tick_ms_r;

  logic [15:0] elapsed_r, elapsed_nxt;

  // captured item
  logic [15:0] assist_r;
  logic [15:0] vel_r;
  logic        fault_r;
  logic        operate_r;
  logic [1:0]  pol_r;

  // working registers
  logic [15:0] absv_r;
  logic [21:0] velmag_r;
  logic        gt_stop_r, le_start_r, ge_stop_r, done_r;
  logic        endneg_r;
  logic [31:0] num_r;
  logic [15:0] den_r;
  logic [15:0] mult_r;
  logic [29:0] dmag_r;
  logic [15:0] cmd_out_r;
  logic [15:0] polar_out_r;
  logic        done_out_r;

  logic [16:0] elapsed_sum;
  logic [31:0] velprod;
  logic [15:0] endmag;
  logic [15:0] tdiff;
  logic [31:0] numprod;
  logic [37:0] dprod;
  logic        div_done;
  logic [15:0] quotient;
  logic [16:0] interp_mult;
  logic [14:0] dclamp;
  logic        vel_pos;
  logic [15:0] damp;
  logic [15:0] torque;
  logic signed [17:0] polar_full;
  logic [15:0] polar_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= '0;
      vel_thr_r   <= '0;
      limit_r     <= '0;
      ramp_strt_r <= '0;
      ramp_stop_r <= '0;
      ramp_end_r  <= '0;
      tick_ms_r   <= fdsr_pkg::TICK_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fdsr_pkg::REG_GAIN:      gain_r      <= cfg_wdata;
        fdsr_pkg::REG_VEL_THR:   vel_thr_r   <= cfg_wdata[14:0];
        fdsr_pkg::REG_LIMIT:     limit_r     <= cfg_wdata[14:0];
        fdsr_pkg::REG_RAMP_STRT: ramp_strt_r <= cfg_wdata;
        fdsr_pkg::REG_RAMP_STOP: ramp_stop_r <= cfg_wdata;
        fdsr_pkg::REG_RAMP_END:  ramp_end_r  <= cfg_wdata;
        fdsr_pkg::REG_TICK_MS:   tick_ms_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // elapsed counter: advance and saturate under fault, clear otherwise
  assign elapsed_sum = {1'b0, elapsed_r} + {9'd0, tick_ms_r};
  always_comb begin
    if (!fault_r) begin
      elapsed_nxt = '0;
    end else if (elapsed_sum[16]) begin
      elapsed_nxt = fdsr_pkg::ELAPSED_MAX;
    end else begin
      elapsed_nxt = elapsed_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cmd.calc) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  assign velprod = absv_r * gain_r;
  assign endmag  = endneg_r ? (fdsr_pkg::UNITY - ramp_end_r)
                            : (ramp_end_r - fdsr_pkg::UNITY);
  assign tdiff   = elapsed_r - ramp_strt_r;
  assign numprod = endmag * tdiff;
  assign dprod   = velmag_r * mult_r;

  // quotient stays below the distance from unity to the end factor, so the
  // sum lies between the two and stays in 16 bits
  assign interp_mult = endneg_r ? ({1'b0, fdsr_pkg::UNITY} - {1'b0, quotient})
                                : ({1'b0, fdsr_pkg::UNITY} + {1'b0, quotient});

  fdsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      assist_r  <= in_tdata[15:0];
      vel_r     <= in_tdata[31:16];
      fault_r   <= in_tdata[32];
      operate_r <= in_tdata[33];
      pol_r     <= in_tdata[35:34];
    end
    if (cmd.calc) begin
      absv_r <= vel_r[15] ? (~vel_r + 16'd1) : vel_r;
    end
    if (cmd.mulv) begin
      velmag_r   <= velprod[31:10];
      gt_stop_r  <= elapsed_r > ramp_stop_r;
      le_start_r <= elapsed_r <= ramp_strt_r;
      ge_stop_r  <= elapsed_r >= ramp_stop_r;
      done_r     <= (elapsed_r >= ramp_stop_r) ||
                    ((elapsed_r > ramp_strt_r) && (absv_r < {1'b0, vel_thr_r}));
      endneg_r   <= ramp_end_r < fdsr_pkg::UNITY;
      den_r      <= ramp_stop_r - ramp_strt_r;
    end
    if (cmd.muln) begin
      num_r <= numprod;
      if (gt_stop_r) begin
        mult_r <= '0;
      end else if (le_start_r) begin
        mult_r <= fdsr_pkg::UNITY;
      end else begin
        mult_r <= ramp_end_r;
      end
    end
    if (div_done) begin
      mult_r <= interp_mult[15:0];
    end
    if (cmd.mul2) begin
      dmag_r <= dprod[37:8];
    end
    if (cmd.fin) begin
      cmd_out_r   <= torque;
      polar_out_r <= polar_sat;
      done_out_r  <= done_r;
    end
  end

  assign sts.interp   = !gt_stop_r && !le_start_r && !ge_stop_r;
  assign sts.div_done = div_done;

  // clamp, oppose the velocity, then select
  assign dclamp  = (dmag_r > {15'd0, limit_r}) ? limit_r : dmag_r[14:0];
  assign vel_pos = !vel_r[15] && (vel_r != 16'd0);
  assign damp    = vel_pos ? (16'd0 - {1'b0, dclamp}) : {1'b0, dclamp};

  always_comb begin
    if (!operate_r || done_r) begin
      torque = '0;
    end else if (fault_r) begin
      torque = damp;
    end else begin
      torque = assist_r;
    end
  end

  assign polar_full = $signed({{2{torque[15]}}, torque}) *
                      $signed({{16{pol_r[1]}}, pol_r});

  always_comb begin
    if (polar_full > 18'sd32767) begin
      polar_sat = fdsr_pkg::SAT_POS;
    end else if (polar_full < -18'sd32768) begin
      polar_sat = fdsr_pkg::SAT_NEG;
    end else begin
      polar_sat = polar_full[15:0];
    end
  end

  assign out_tdata = {7'd0, done_out_r, polar_out_r, cmd_out_r};

endmodule

// File: rtl/fault_damping_shutdown_ramp.sv
// Channel | Direction | Handshake            | Content
// in_     | input     | in_tvalid/in_tready   | one tick: torque, velocity, flags
// out_    | output    | out_tvalid/out_tready | torque command, polar copy, done
// cfg_    | input     | cfg_we                | register index and write data
//
// An item passes the calc, multiply and finish steps; when the elapsed time
// lies strictly inside the ramp, the 32-step serial divider runs before the
// second multiply. A new item is taken only once the last one is finished.
// rst_n is synchronous: it clears the sequencer, the output valid, the
// elapsed counter and loads the register reset values.
// A stalled output holds in its register; the next item is accepted meanwhile
// and waits in its last step until the register frees up.
module fault_damping_shutdown_ramp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fdsr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [fdsr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] assist_torque, [31:16] motor_velocity, [32] fault_active,
  // [33] operate_mode, [35:34] assembly_polarity, [39:36] zero
  input  logic [fdsr_pkg::IN_DW-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] torque_cmd, [31:16] torque_cmd_polar, [32] damping_done,
  // [39:33] zero
  output logic [fdsr_pkg::OUT_DW-1:0] out_tdata
);

  fdsr_pkg::dp_cmd_t cmd;
  fdsr_pkg::dp_sts_t sts;

  fdsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fdsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: rtl/fdsr_chk.sv
module fdsr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_we,
  input logic [fdsr_pkg::CFG_AW-1:0] cfg_addr,
  input logic [fdsr_pkg::CFG_DW-1:0] cfg_wdata,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [fdsr_pkg::IN_DW-1:0]  in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [fdsr_pkg::OUT_DW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero torque with shutdown complete");

endmodule

bind fault_damping_shutdown_ramp fdsr_chk u_chk (.*);
